// ===== hw/rtl/msc_pkg.sv =====
// Shared types and constants for the multi-axis step chaser.
`timescale 1ns / 1ps

package msc_pkg;

	localparam int AXES      = 4;
	localparam int POS_BITS  = 32;
	localparam int DIST_BITS = POS_BITS + 1;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef struct packed {
		logic step;
		logic dir;
		logic near;  // remaining distance is zero or one count
	} lane_stat_t;

	typedef struct packed {
		logic [AXES-1:0] step_bits;
		logic [AXES-1:0] dir_bits;
		logic            last;
	} result_t;

endpackage

// ===== hw/rtl/msc_lane.sv =====
// One axis lane: remaining signed distance to target and its step/dir status.
`timescale 1ns / 1ps

module msc_lane (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 load,
	input  logic                                 adv,
	input  logic signed [msc_pkg::POS_BITS-1:0]  start,
	input  logic signed [msc_pkg::POS_BITS-1:0]  dest,
	output msc_pkg::lane_stat_t                  stat
);
	import msc_pkg::*;

	logic signed [DIST_BITS-1:0] dist_q;

	// Distance kept one bit wider than a position so it never overflows.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q <= '0;
		end else if (load) begin
			dist_q <= {dest[POS_BITS-1], dest} - {start[POS_BITS-1], start};
		end else if (adv && stat.step) begin
			if (stat.dir) begin
				dist_q <= dist_q - DIST_BITS'(1);
			end else begin
				dist_q <= dist_q + DIST_BITS'(1);
			end
		end
	end

	always_comb begin
		stat.step = (dist_q != '0);
		stat.dir  = !dist_q[DIST_BITS-1] && stat.step;
		stat.near = (dist_q == '0) || (dist_q == DIST_BITS'(1)) || (dist_q == '1);
	end

endmodule

// ===== hw/rtl/msc_merge.sv =====
// Merges the lane status into one step command.
`timescale 1ns / 1ps

module msc_merge (
	input  msc_pkg::lane_stat_t stat [msc_pkg::AXES],
	output msc_pkg::result_t    res
);
	import msc_pkg::*;

	logic [AXES-1:0] near_bits;

	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			res.step_bits[i] = stat[i].step;
			res.dir_bits[i]  = stat[i].dir;
			near_bits[i]     = stat[i].near;
		end
		// Final command once every axis is within one count of its target.
		res.last = &near_bits;
	end

endmodule

// ===== hw/rtl/msc_obuf.sv =====
// Output register with a skid entry so input stall is a registered signal.
`timescale 1ns / 1ps

module msc_obuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_valid,
	input  msc_pkg::result_t res,
	output logic             full,
	output logic             out_valid,
	output msc_pkg::result_t out_res,
	input  logic             out_stall
);
	import msc_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_res_q;
	result_t skid_res_q;
	logic    out_take;

	assign out_take  = out_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || out_take) begin
			out_valid_q <= res_valid;
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_res_q <= skid_res_q;
			end
		end else if (!out_valid_q || out_take) begin
			out_res_q <= res;
		end else if (res_valid) begin
			skid_res_q <= res;
		end
	end

endmodule

// ===== hw/rtl/multi_axis_step_chaser.sv =====
// A tick's step command is registered in the output buffer, or in its skid entry while the output stalls.
// Throughput: one transaction per cycle while in_stall is low, loads and ticks in any mix.
// Each axis lane holds its own remaining distance; lanes update in parallel.
// in_stall is registered (skid entry full), so it rises in the cycle after a result arrives while out_stall holds.
// Reset clears distances, the move-active flag and the output buffer.
`timescale 1ns / 1ps

module multi_axis_step_chaser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [31:0] start_0,
	input  logic [31:0] start_1,
	input  logic [31:0] start_2,
	input  logic [31:0] start_3,
	input  logic [31:0] dest_0,
	input  logic [31:0] dest_1,
	input  logic [31:0] dest_2,
	input  logic [31:0] dest_3,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  step_bits,
	output logic [3:0]  dir_bits,
	output logic        last
);
	import msc_pkg::*;

	logic                       accept;
	logic                       load;
	logic                       fire;
	logic                       active_q;
	logic signed [POS_BITS-1:0] start_a [AXES];
	logic signed [POS_BITS-1:0] dest_a  [AXES];
	lane_stat_t                 stat    [AXES];
	result_t                    res;
	result_t                    out_res;

	assign start_a[0] = start_0;
	assign start_a[1] = start_1;
	assign start_a[2] = start_2;
	assign start_a[3] = start_3;
	assign dest_a[0]  = dest_0;
	assign dest_a[1]  = dest_1;
	assign dest_a[2]  = dest_2;
	assign dest_a[3]  = dest_3;

	assign accept = in_valid && !in_stall;
	assign load   = accept && (op == OP_LOAD);
	assign fire   = accept && (op == OP_TICK) && active_q;

	// Budget remains while active: a load always leaves at least one command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (load) begin
			active_q <= 1'b1;
		end else if (fire && res.last) begin
			active_q <= 1'b0;
		end
	end

	for (genvar g = 0; g < AXES; g++) begin : g_lane
		msc_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.load   (load),
			.adv    (fire),
			.start  (start_a[g]),
			.dest   (dest_a[g]),
			.stat   (stat[g])
		);
	end

	msc_merge u_merge (
		.stat (stat),
		.res  (res)
	);

	msc_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (fire),
		.res       (res),
		.full      (in_stall),
		.out_valid (out_valid),
		.out_res   (out_res),
		.out_stall (out_stall)
	);

	assign step_bits = out_res.step_bits;
	assign dir_bits  = out_res.dir_bits;
	assign last      = out_res.last;

endmodule

// ===== hw/rtl/msc_checker.sv =====
// Port-level checks for the multi-axis step chaser, bound to the top level.
`timescale 1ns / 1ps

module msc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic op,
	input logic out_valid,
	input logic out_stall
);
	import msc_pkg::*;

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// Input backpressure only while a result is held in the output register.
	a_stall_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output");

	// Input stall only comes after the output side stalled.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("input stall without output stall");

	// A load transaction never produces a result.
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (op == OP_LOAD) && !out_valid |=> !out_valid)
		else $error("result produced by load");

endmodule

bind multi_axis_step_chaser msc_checker u_msc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.op        (op),
	.out_valid (out_valid),
	.out_stall (out_stall)
);
